### design/limm_pkg.sv
// Shared constants, codes and types of the lane-interleaved int8 matmul block.
`default_nettype none
package limm_pkg;

	localparam int IDX_W      = 6;
	localparam int IDX_N      = 2 ** IDX_W;
	localparam int BYTE_W     = 8;
	localparam int WORD_LANES = 4;
	localparam int WORD_W     = BYTE_W * WORD_LANES;
	localparam int KLEN_W     = 7;
	localparam int PROD_W     = 2 * BYTE_W;

	localparam logic [KLEN_W-1:0] KLEN_RST = 7'd64;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_K_DEF    = 64;
	localparam int LANES_DEF    = 4;

	typedef enum logic [1:0] {
		REQ_WR_LEFT  = 2'd0,
		REQ_WR_RIGHT = 2'd1,
		REQ_COMPUTE  = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
	} lane_ctl_t;

endpackage
`default_nettype wire

### design/limm_if.sv
// Command and result channel interfaces.
`default_nettype none
interface limm_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          req_type;
	logic [limm_pkg::IDX_W-1:0]          left_row;
	logic [limm_pkg::IDX_W-1:0]          right_col;
	logic [limm_pkg::IDX_W-1:0]          k_index;
	logic signed [limm_pkg::BYTE_W-1:0]  value_lane0;
	logic signed [limm_pkg::BYTE_W-1:0]  value_lane1;
	logic signed [limm_pkg::BYTE_W-1:0]  value_lane2;
	logic signed [limm_pkg::BYTE_W-1:0]  value_lane3;

	modport source (
		output valid, req_type, left_row, right_col, k_index,
		output value_lane0, value_lane1, value_lane2, value_lane3,
		input  ready
	);
	modport sink (
		input  valid, req_type, left_row, right_col, k_index,
		input  value_lane0, value_lane1, value_lane2, value_lane3,
		output ready
	);
endinterface

interface limm_res_if;
	logic                                valid;
	logic                                ready;
	logic [limm_pkg::IDX_W-1:0]          out_row;
	logic [limm_pkg::IDX_W-1:0]          out_col;
	logic signed [limm_pkg::BYTE_W-1:0]  result_lane0;
	logic signed [limm_pkg::BYTE_W-1:0]  result_lane1;
	logic signed [limm_pkg::BYTE_W-1:0]  result_lane2;
	logic signed [limm_pkg::BYTE_W-1:0]  result_lane3;

	modport source (
		output valid, out_row, out_col,
		output result_lane0, result_lane1, result_lane2, result_lane3,
		input  ready
	);
	modport sink (
		input  valid, out_row, out_col,
		input  result_lane0, result_lane1, result_lane2, result_lane3,
		output ready
	);
endinterface
`default_nettype wire

### design/limm_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module limm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

### design/limm_ctrl.sv
// Sequencer: command decode, store addressing, k walk and lane pipeline control.
`default_nettype none
module limm_ctrl #(
	parameter int MAX_ROWS = limm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = limm_pkg::MAX_COLS_DEF,
	parameter int MAX_K    = limm_pkg::MAX_K_DEF,
	localparam int LD      = MAX_ROWS * MAX_K,
	localparam int RD      = MAX_COLS * MAX_K,
	localparam int LA_W    = (LD > 1) ? $clog2(LD) : 1,
	localparam int RA_W    = (RD > 1) ? $clog2(RD) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [limm_pkg::KLEN_W-1:0]   cfg_wr_data,
	limm_cmd_if.sink                           cmd,
	input  wire logic                          out_free,
	output logic                               l_we,
	output logic                               r_we,
	output logic [LA_W-1:0]                    l_waddr,
	output logic [RA_W-1:0]                    r_waddr,
	output logic [limm_pkg::WORD_W-1:0]        wdata,
	output logic                               rd_en,
	output logic [LA_W-1:0]                    l_raddr,
	output logic [RA_W-1:0]                    r_raddr,
	output limm_pkg::lane_ctl_t                lane_ctl,
	output logic                               load,
	output logic [limm_pkg::IDX_W-1:0]         row,
	output logic [limm_pkg::IDX_W-1:0]         col
);

	localparam int AMAX   = (LA_W > RA_W) ? LA_W : RA_W;
	localparam int ADR_W  = AMAX + limm_pkg::IDX_W + 1;
	localparam int KW     = limm_pkg::KLEN_W;
	localparam int IW     = limm_pkg::IDX_W;

	limm_pkg::state_t state_q, state_d;

	logic [KW-1:0] k_length_q;
	logic [KW-1:0] klen_eff;
	logic [KW-1:0] klim_q;
	logic [KW-1:0] kcnt_q;
	logic [IW-1:0] row_q, col_q;
	logic          rdv_s1, last_s1, mulv_s2, last_s2;

	logic [IW-1:0] row_tab [limm_pkg::IDX_N];
	logic [IW-1:0] col_tab [limm_pkg::IDX_N];
	logic [IW-1:0] k_tab   [limm_pkg::IDX_N];
	logic [IW-1:0] row_m, col_m, kix_m;

	logic          accept, is_cmp, rd_last;
	logic [ADR_W-1:0] lw_full, rw_full, lr_full, rr_full;

	for (genvar g = 0; g < limm_pkg::IDX_N; g++) begin : g_tab
		assign row_tab[g] = IW'(g % MAX_ROWS);
		assign col_tab[g] = IW'(g % MAX_COLS);
		assign k_tab[g]   = IW'(g % MAX_K);
	end

	assign row_m = row_tab[cmd.left_row];
	assign col_m = col_tab[cmd.right_col];
	assign kix_m = k_tab[cmd.k_index];

	assign klen_eff = (32'(k_length_q) > 32'(MAX_K)) ? KW'(MAX_K) : k_length_q;

	assign accept = cmd.valid && cmd.ready;
	assign is_cmp = (cmd.req_type == limm_pkg::REQ_COMPUTE);

	assign lw_full = ADR_W'(row_m) * ADR_W'(MAX_K) + ADR_W'(kix_m);
	assign rw_full = ADR_W'(col_m) * ADR_W'(MAX_K) + ADR_W'(kix_m);
	assign lr_full = ADR_W'(row_q) * ADR_W'(MAX_K) + ADR_W'(kcnt_q);
	assign rr_full = ADR_W'(col_q) * ADR_W'(MAX_K) + ADR_W'(kcnt_q);

	assign l_waddr = lw_full[LA_W-1:0];
	assign r_waddr = rw_full[RA_W-1:0];
	assign l_raddr = lr_full[LA_W-1:0];
	assign r_raddr = rr_full[RA_W-1:0];
	assign wdata   = {cmd.value_lane3, cmd.value_lane2, cmd.value_lane1, cmd.value_lane0};
	assign row     = row_q;
	assign col     = col_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			limm_pkg::ST_IDLE: begin
				if (accept && is_cmp) begin
					state_d = (klen_eff == '0) ? limm_pkg::ST_FIN : limm_pkg::ST_RUN;
				end
			end
			limm_pkg::ST_RUN: begin
				if (kcnt_q == klim_q - KW'(1)) begin
					state_d = limm_pkg::ST_WAIT;
				end
			end
			limm_pkg::ST_WAIT: begin
				if (last_s2) begin
					state_d = limm_pkg::ST_FIN;
				end
			end
			limm_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = limm_pkg::ST_IDLE;
				end
			end
			default: state_d = limm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready       = (state_q == limm_pkg::ST_IDLE);
		rd_en           = (state_q == limm_pkg::ST_RUN);
		rd_last         = rd_en && (kcnt_q == klim_q - KW'(1));
		load            = (state_q == limm_pkg::ST_FIN) && out_free;
		l_we            = accept && (cmd.req_type == limm_pkg::REQ_WR_LEFT);
		r_we            = accept && (cmd.req_type == limm_pkg::REQ_WR_RIGHT);
		lane_ctl.clr    = accept && is_cmp;
		lane_ctl.mul_en = rdv_s1;
		lane_ctl.acc_en = mulv_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= limm_pkg::ST_IDLE;
			k_length_q <= limm_pkg::KLEN_RST;
			rdv_s1     <= 1'b0;
			last_s1    <= 1'b0;
			mulv_s2    <= 1'b0;
			last_s2    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				k_length_q <= cfg_wr_data;
			end
			rdv_s1  <= rd_en;
			last_s1 <= rd_last;
			mulv_s2 <= rdv_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_cmp) begin
			row_q  <= row_m;
			col_q  <= col_m;
			klim_q <= klen_eff;
			kcnt_q <= '0;
		end else if (rd_en) begin
			kcnt_q <= kcnt_q + KW'(1);
		end
	end

endmodule
`default_nettype wire

### design/limm_lane.sv
// One lane: signed byte multiply, then modulo-256 accumulate.
`default_nettype none
module limm_lane (
	input  wire logic                                  clk,
	input  wire limm_pkg::lane_ctl_t                   ctl,
	input  wire logic signed [limm_pkg::BYTE_W-1:0]    a,
	input  wire logic signed [limm_pkg::BYTE_W-1:0]    b,
	output logic             [limm_pkg::BYTE_W-1:0]    acc
);

	logic signed [limm_pkg::PROD_W-1:0] prod_s2;
	logic        [limm_pkg::BYTE_W-1:0] acc_q;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s2 <= a * b;
		end
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + prod_s2[limm_pkg::BYTE_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

### design/limm_merge.sv
// Merge stage: gathers lane sums into the result word register.
`default_nettype none
module limm_merge #(
	parameter int LANES = limm_pkg::LANES_DEF
) (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          load,
	input  wire logic [limm_pkg::IDX_W-1:0]                    row,
	input  wire logic [limm_pkg::IDX_W-1:0]                    col,
	input  wire logic [LANES-1:0][limm_pkg::BYTE_W-1:0]        acc,
	output logic                                               free,
	limm_res_if.source                                         res
);

	logic [limm_pkg::WORD_LANES-1:0][limm_pkg::BYTE_W-1:0] lane_res;
	logic [limm_pkg::WORD_LANES-1:0][limm_pkg::BYTE_W-1:0] lane_q;
	logic [limm_pkg::IDX_W-1:0] row_q, col_q;
	logic valid_q;

	for (genvar i = 0; i < limm_pkg::WORD_LANES; i++) begin : g_res
		if (i < LANES) begin : g_on
			assign lane_res[i] = acc[i];
		end else begin : g_off
			assign lane_res[i] = '0;
		end
	end

	assign free = !valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q  <= row;
			col_q  <= col;
			lane_q <= lane_res;
		end
	end

	assign res.valid        = valid_q;
	assign res.out_row      = row_q;
	assign res.out_col      = col_q;
	assign res.result_lane0 = $signed(lane_q[0]);
	assign res.result_lane1 = $signed(lane_q[1]);
	assign res.result_lane2 = $signed(lane_q[2]);
	assign res.result_lane3 = $signed(lane_q[3]);

endmodule
`default_nettype wire

### design/lane_interleaved_int8_matmul.sv
// Top level of the lane-interleaved int8 matrix multiply element engine.
//
//   channel   dir   handshake          word
//   cmd       in    valid/ready        req_type, left_row, right_col, k_index, value_lane0..3
//   res       out   valid/ready        out_row, out_col, result_lane0..3
//   cfg       in    cfg_wr_en          cfg_wr_data = k_length
//
// A compute reads min(k_length, MAX_K) words from both stores, one word per cycle through
// their single read port, then the multiply and accumulate stages drain; a zero k_length
// skips the reads. One item is in work at a time; the result register lets the next item
// in while a result waits. arst_n clears control only, store contents are undefined until
// written. A stalled res holds the finished compute in its last state.
`default_nettype none
module lane_interleaved_int8_matmul #(
	parameter int MAX_ROWS = limm_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = limm_pkg::MAX_COLS_DEF,
	parameter int MAX_K    = limm_pkg::MAX_K_DEF,
	parameter int LANES    = limm_pkg::LANES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [limm_pkg::KLEN_W-1:0]   cfg_wr_data,
	limm_cmd_if.sink                           cmd,
	limm_res_if.source                         res
);

	localparam int LD   = MAX_ROWS * MAX_K;
	localparam int RD   = MAX_COLS * MAX_K;
	localparam int LA_W = (LD > 1) ? $clog2(LD) : 1;
	localparam int RA_W = (RD > 1) ? $clog2(RD) : 1;
	localparam int BW   = limm_pkg::BYTE_W;

	logic                          l_we, r_we, rd_en, load, out_free;
	logic [LA_W-1:0]               l_waddr, l_raddr;
	logic [RA_W-1:0]               r_waddr, r_raddr;
	logic [limm_pkg::WORD_W-1:0]   wdata, l_rdata, r_rdata;
	limm_pkg::lane_ctl_t           lane_ctl;
	logic [limm_pkg::IDX_W-1:0]    row, col;
	logic [LANES-1:0][BW-1:0]      acc;

	limm_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_K    (MAX_K)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.out_free    (out_free),
		.l_we        (l_we),
		.r_we        (r_we),
		.l_waddr     (l_waddr),
		.r_waddr     (r_waddr),
		.wdata       (wdata),
		.rd_en       (rd_en),
		.l_raddr     (l_raddr),
		.r_raddr     (r_raddr),
		.lane_ctl    (lane_ctl),
		.load        (load),
		.row         (row),
		.col         (col)
	);

	limm_ram #(
		.WIDTH (limm_pkg::WORD_W),
		.DEPTH (LD)
	) u_left_store (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	limm_ram #(
		.WIDTH (limm_pkg::WORD_W),
		.DEPTH (RD)
	) u_right_store (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (r_raddr),
		.rdata (r_rdata)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		limm_lane u_lane (
			.clk (clk),
			.ctl (lane_ctl),
			.a   ($signed(l_rdata[i*BW +: BW])),
			.b   ($signed(r_rdata[i*BW +: BW])),
			.acc (acc[i])
		);
	end

	limm_merge #(
		.LANES (LANES)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.row    (row),
		.col    (col),
		.acc    (acc),
		.free   (out_free),
		.res    (res)
	);

endmodule
`default_nettype wire

### design/limm_checker.sv
// Port-level checker for the matmul engine and its bind to the top level.
`default_nettype none
module limm_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cmd_valid,
	input wire logic        cmd_ready,
	input wire logic [1:0]  cmd_type,
	input wire logic        res_valid,
	input wire logic        res_ready,
	input wire logic [43:0] res_data
);

	logic cmd_acc;
	assign cmd_acc = cmd_valid && cmd_ready;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result word changed while stalled");

	a_cmp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (cmd_type == limm_pkg::REQ_COMPUTE) |=> !cmd_ready)
		else $error("command taken while compute in progress");

	a_wr_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && (cmd_type != limm_pkg::REQ_COMPUTE) |=> cmd_ready)
		else $error("write stalled the command channel");

	a_res_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> cmd_ready)
		else $error("result issued before compute finished");

endmodule

bind lane_interleaved_int8_matmul limm_checker u_limm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_type  (cmd.req_type),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  ({res.out_row, res.out_col, res.result_lane3, res.result_lane2,
		res.result_lane1, res.result_lane0})
);
`default_nettype wire

### tb/limm_checker.sv
// Checker for the int8 matmul engine: mirrors both stores, predicts each product and compares.
`timescale 1ns / 100ps
module limm_scoreboard
	import limm_pkg::*;
#(
	parameter int LANES = LANES_DEF,
	parameter int MAX_K = MAX_K_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [KLEN_W-1:0] cfg_wr_data,
	limm_cmd_if               cmd,
	limm_res_if               res,
	output int                mismatches,
	output int                results_seen,
	output int                waiting
);

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [WORD_W-1:0] lanes;
	} product_t;

	logic [WORD_W-1:0] left_words [IDX_N*IDX_N];
	logic [WORD_W-1:0] right_words [IDX_N*IDX_N];
	logic [KLEN_W-1:0] k_len;
	product_t          product_q[$];

	function automatic product_t predict_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
		product_t          p;
		int                n;
		int                prod;
		logic [BYTE_W-1:0] acc [WORD_LANES];
		logic [WORD_W-1:0] lw;
		logic [WORD_W-1:0] rw;
		n = (k_len > MAX_K) ? MAX_K : k_len;
		foreach (acc[i]) acc[i] = '0;
		for (int k = 0; k < n; k++) begin
			lw = left_words[{row, IDX_W'(k)}];
			rw = right_words[{col, IDX_W'(k)}];
			for (int ln = 0; ln < LANES; ln++) begin
				prod = $signed(lw[BYTE_W*ln +: BYTE_W]) * $signed(rw[BYTE_W*ln +: BYTE_W]);
				acc[ln] = acc[ln] + prod[BYTE_W-1:0];
			end
		end
		p.row = row;
		p.col = col;
		p.lanes = {acc[3], acc[2], acc[1], acc[0]};
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		product_t          want;
		logic [WORD_W-1:0] got;
		logic [WORD_W-1:0] cmd_word;
		int                errs;
		if (!arst_n) begin
			k_len <= KLEN_RST;
			product_q.delete();
			mismatches <= 0;
			results_seen <= 0;
			waiting <= 0;
		end else begin
			errs = 0;
			if (cfg_wr_en) begin
				k_len <= cfg_wr_data;
			end
			if (res.valid && res.ready) begin
				results_seen <= results_seen + 1;
				got = {res.result_lane3, res.result_lane2, res.result_lane1, res.result_lane0};
				if (product_q.size() == 0) begin
					$error("result word with no product pending: row %0d col %0d",
						res.out_row, res.out_col);
					errs++;
				end else begin
					want = product_q.pop_front();
					if (res.out_row !== want.row) begin
						$error("out_row: expected %0d, actual %0d", want.row, res.out_row);
						errs++;
					end
					if (res.out_col !== want.col) begin
						$error("out_col: expected %0d, actual %0d", want.col, res.out_col);
						errs++;
					end
					for (int ln = 0; ln < WORD_LANES; ln++) begin
						if (got[BYTE_W*ln +: BYTE_W] !== want.lanes[BYTE_W*ln +: BYTE_W]) begin
							$error("result_lane%0d: expected %0d, actual %0d", ln,
								$signed(want.lanes[BYTE_W*ln +: BYTE_W]),
								$signed(got[BYTE_W*ln +: BYTE_W]));
							errs++;
						end
					end
				end
			end
			if (cmd.valid && cmd.ready) begin
				cmd_word = {cmd.value_lane3, cmd.value_lane2, cmd.value_lane1, cmd.value_lane0};
				case (cmd.req_type)
					REQ_WR_LEFT: begin
						left_words[{cmd.left_row, cmd.k_index}] <= cmd_word;
					end
					REQ_WR_RIGHT: begin
						right_words[{cmd.right_col, cmd.k_index}] <= cmd_word;
					end
					REQ_COMPUTE: begin
						product_q.push_back(predict_product(cmd.left_row, cmd.right_col));
					end
					default: begin
					end
				endcase
			end
			mismatches <= mismatches + errs;
			waiting <= product_q.size();
		end
	end

endmodule

### tb/tb.sv
// Testbench top for the int8 matmul engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps
module tb;
	import limm_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 80;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [KLEN_W-1:0] cfg_wr_data = '0;

	int mismatches;
	int results_seen;
	int waiting;
	int counted;
	int computes_sent;
	int klen_writes;
	int stall_cycles;
	int snd_idle;
	int rcv_idle;
	int klen_eff;
	bit have_word [0:1][0:IDX_N-1][0:IDX_N-1];

	limm_cmd_if cmd_ch ();
	limm_res_if res_ch ();

	lane_interleaved_int8_matmul dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd_ch),
		.res         (res_ch)
	);

	limm_scoreboard chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd_ch),
		.res          (res_ch),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.waiting      (waiting)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h8080_8080;
			1: return 32'h7f7f_7f7f;
			default: return $urandom();
		endcase
	endfunction

	function automatic int pick_ready(req_t side, int keff);
		int  ready_q[$];
		bit  ok;
		for (int i = 0; i < IDX_N; i++) begin
			ok = 1'b1;
			for (int k = 0; k < keff; k++) begin
				if (!have_word[side][i][k]) ok = 1'b0;
			end
			if (ok) ready_q.push_back(i);
		end
		if (ready_q.size() == 0) return -1;
		return ready_q[$urandom_range(ready_q.size() - 1)];
	endfunction

	task automatic send_word(input req_t req, input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] kix,
			input logic [WORD_W-1:0] lanes);
		bit ok;
		if (counted < 317) begin
			snd_idle = 24;
			rcv_idle = 88;
		end else if (counted < 634) begin
			snd_idle = 88;
			rcv_idle = 24;
		end else begin
			snd_idle = 0;
			rcv_idle = 0;
		end
		while ($urandom_range(99) < snd_idle) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.req_type <= req;
		cmd_ch.left_row <= row;
		cmd_ch.right_col <= col;
		cmd_ch.k_index <= kix;
		cmd_ch.value_lane0 <= lanes[7:0];
		cmd_ch.value_lane1 <= lanes[15:8];
		cmd_ch.value_lane2 <= lanes[23:16];
		cmd_ch.value_lane3 <= lanes[31:24];
		do begin
			@(negedge clk);
			ok = cmd_ch.ready;
			@(posedge clk);
		end while (!ok);
		case (req)
			REQ_WR_LEFT: have_word[REQ_WR_LEFT][row][kix] = 1'b1;
			REQ_WR_RIGHT: have_word[REQ_WR_RIGHT][col][kix] = 1'b1;
			REQ_COMPUTE: computes_sent++;
			default: ;
		endcase
		if (req != REQ_NONE) counted++;
	endtask

	task automatic wait_for_products();
		cmd_ch.valid <= 1'b0;
		while (results_seen != computes_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_k_length(input logic [KLEN_W-1:0] klen);
		wait_for_products();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= klen;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		klen_eff = (klen > MAX_K_DEF) ? MAX_K_DEF : klen;
		klen_writes++;
	endtask

	task automatic fill_prefix(input req_t side, input int idx, input int keff);
		for (int k = 0; k < keff; k++) begin
			if (!have_word[side][idx][k] || $urandom_range(15) == 0) begin
				send_word(side,
					(side == REQ_WR_LEFT) ? IDX_W'(idx) : IDX_W'($urandom_range(IDX_N - 1)),
					(side == REQ_WR_RIGHT) ? IDX_W'(idx) : IDX_W'($urandom_range(IDX_N - 1)),
					IDX_W'(k), rand_word());
			end
		end
	endtask

	task automatic run_phase(input logic [KLEN_W-1:0] klen, input int n_items);
		int start;
		int pick;
		int r;
		int c;
		set_k_length(klen);
		start = counted;
		while (counted - start < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				r = pick_ready(REQ_WR_LEFT, klen_eff);
				if (r < 0 || $urandom_range(9) < 3) r = $urandom_range(IDX_N - 1);
				c = pick_ready(REQ_WR_RIGHT, klen_eff);
				if (c < 0 || $urandom_range(9) < 3) c = $urandom_range(IDX_N - 1);
				fill_prefix(REQ_WR_LEFT, r, klen_eff);
				fill_prefix(REQ_WR_RIGHT, c, klen_eff);
				send_word(REQ_COMPUTE, IDX_W'(r), IDX_W'(c),
					IDX_W'($urandom_range(IDX_N - 1)), rand_word());
			end else if (pick < 80) begin
				r = pick_ready(REQ_WR_LEFT, klen_eff);
				c = pick_ready(REQ_WR_RIGHT, klen_eff);
				if (r >= 0 && c >= 0) begin
					send_word(REQ_COMPUTE, IDX_W'(r), IDX_W'(c),
						IDX_W'($urandom_range(IDX_N - 1)), rand_word());
				end
			end else if (pick < 93) begin
				send_word(($urandom_range(1) != 0) ? REQ_WR_RIGHT : REQ_WR_LEFT,
					IDX_W'($urandom_range(IDX_N - 1)), IDX_W'($urandom_range(IDX_N - 1)),
					IDX_W'($urandom_range(IDX_N - 1)), rand_word());
			end else begin
				send_word(REQ_NONE, IDX_W'($urandom_range(IDX_N - 1)),
					IDX_W'($urandom_range(IDX_N - 1)), IDX_W'($urandom_range(IDX_N - 1)),
					rand_word());
			end
		end
	endtask

	initial begin
		cmd_ch.valid <= 1'b0;
		cmd_ch.req_type <= REQ_NONE;
		cmd_ch.left_row <= '0;
		cmd_ch.right_col <= '0;
		cmd_ch.k_index <= '0;
		cmd_ch.value_lane0 <= '0;
		cmd_ch.value_lane1 <= '0;
		cmd_ch.value_lane2 <= '0;
		cmd_ch.value_lane3 <= '0;
		klen_eff = MAX_K_DEF;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_k_length(7'd2);
		send_word(REQ_WR_LEFT, 0, 0, 0, 32'h8080_8080);
		send_word(REQ_WR_LEFT, 0, 0, 1, 32'h7f7f_7f7f);
		send_word(REQ_WR_RIGHT, 0, 0, 0, 32'h8080_8080);
		send_word(REQ_WR_RIGHT, 0, 0, 1, 32'h8080_8080);
		send_word(REQ_WR_LEFT, 63, 0, 0, 32'h7f7f_7f7f);
		send_word(REQ_WR_LEFT, 63, 63, 1, 32'h01ff_807f);
		send_word(REQ_WR_RIGHT, 63, 63, 0, 32'h7f80_7f80);
		send_word(REQ_WR_RIGHT, 0, 63, 1, 32'hffff_ffff);
		send_word(REQ_WR_RIGHT, 63, 5, 63, 32'h807f_00ff);
		send_word(REQ_COMPUTE, 0, 0, 0, '0);
		send_word(REQ_COMPUTE, 63, 63, 63, 32'hffff_ffff);
		send_word(REQ_COMPUTE, 0, 63, 0, '0);
		send_word(REQ_COMPUTE, 63, 0, 0, '0);
		send_word(REQ_NONE, 0, 0, 0, 32'h5555_5555);
		send_word(REQ_NONE, 63, 63, 1, 32'haaaa_aaaa);
		send_word(REQ_COMPUTE, 0, 0, 0, '0);
		set_k_length(7'd0);
		send_word(REQ_COMPUTE, 17, 42, 0, '0);
		send_word(REQ_COMPUTE, 63, 63, 0, '0);
		set_k_length(7'd1);
		send_word(REQ_COMPUTE, 0, 63, 0, '0);
		send_word(REQ_COMPUTE, 63, 0, 0, '0);

		run_phase(7'd127, 200);
		run_phase(7'd64, 120);
		run_phase(7'd1, 150);
		run_phase(7'd5, 150);
		run_phase(7'd0, 60);
		repeat (3) run_phase(KLEN_W'($urandom_range(63, 2)), 90);

		wait_for_products();
		$display("Sent %0d command words (%0d computes) over %0d k_length settings,",
			counted, computes_sent, klen_writes);
		$display("zero and saturated lengths included; %0d result words checked.",
			results_seen);
		if (mismatches == 0 && waiting == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
